FILE: design/csvt_pkg.sv
// Shared types, codes and constants of the CSV record tokenizer.
`default_nettype none

package csvt_pkg;

   localparam int MAX_FIELDS = 16;

   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 4;
   localparam int COUNT_W     = 5;
   localparam int ERR_W       = 3;
   localparam int LINE_LEN_W  = 29;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 29;

   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_UNCLOSED = 3'd1;
   localparam logic [ERR_W-1:0] ERR_JUNK     = 3'd2;
   localparam logic [ERR_W-1:0] ERR_TOO_MANY = 3'd3;
   localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd4;
   localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_FIELDS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LINE_BYTES  = 1'd1;

   localparam logic [COUNT_W-1:0]    RESET_EXPECTED = 5'd10;
   localparam logic [LINE_LEN_W-1:0] RESET_MAX_LINE = 29'd536870910;

   typedef enum logic [2:0] {
      MODE_LINE_START  = 3'd0,
      MODE_SKIP        = 3'd1,
      MODE_FIELD_START = 3'd2,
      MODE_UNQUOTED    = 3'd3,
      MODE_QUOTED      = 3'd4,
      MODE_QUOTE_SEEN  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_input;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic [INDEX_W-1:0] field_index;
      logic               field_end;
      logic               record_end;
      logic [COUNT_W-1:0] field_count;
      logic [ERR_W-1:0]   error_code;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/csvt_channels.sv
// Valid/ready channel interfaces for input words, result words and register writes.
`default_nettype none

interface csvt_req_if;
   logic              valid;
   logic              ready;
   csvt_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface csvt_rsp_if;
   logic              valid;
   logic              ready;
   csvt_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface csvt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [csvt_pkg::CSR_IDX_W-1:0]     index;
   logic [csvt_pkg::CSR_DATA_W-1:0]    wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: design/csv_record_tokenizer_unit.sv
// CSV record tokenizer: splits a byte stream into fields and records.
// Pipeline: input register, then result register; an accepted input word yields a result
//    word that is offered from the result register.
// Throughput: 1 word per cycle when the result channel is not stalled; the per-byte
//    parse mode and counter update is combinational between the two registers.
// Reset: synchronous, active high; clears parse state, error halt and pipeline
//    valids, and loads expected_fields = 10, max_line_bytes = 536870910.
`default_nettype none

module csv_record_tokenizer_unit (
   input  wire          clock,
   input  wire          reset,
   csvt_req_if.sink     req_chan,
   csvt_rsp_if.source   rsp_chan,
   csvt_csr_if.sink     csr_chan
);

   // handshake
   logic req_ready;
   logic req_fire;
   logic rsp_ready;
   logic advance;
   logic process;

   // input stage
   logic              in_valid_ff, in_valid_in;
   csvt_pkg::req_type in_ff;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   csvt_pkg::rsp_type rsp_ff, result;

   // configuration
   logic [csvt_pkg::COUNT_W-1:0]    expected_ff;
   logic [csvt_pkg::LINE_LEN_W-1:0] max_line_ff;

   // parse state
   csvt_pkg::mode_type              mode_ff, mode_in;
   logic [csvt_pkg::COUNT_W-1:0]    fields_ff, fields_in;
   logic [csvt_pkg::LINE_LEN_W-1:0] len_ff, len_in;
   logic                            crp_ff, crp_in;
   logic                            halt_ff, halt_in;

   // step decode
   logic [csvt_pkg::BYTE_W-1:0]  c;
   logic [csvt_pkg::COUNT_W-1:0] fs;
   logic [csvt_pkg::COUNT_W-1:0] rec_count;
   logic                         line_end;
   logic                         start_field;
   logic                         end_field;
   logic                         emit;
   logic                         rec_ok;
   logic                         rec_fend;

   assign rsp_ready = rsp_chan.ready;
   assign advance   = !rsp_valid_ff || rsp_ready;
   // hold off input words while reset is high
   assign req_ready = !reset && (!in_valid_ff || advance);
   assign req_fire  = req_chan.valid && req_ready;
   assign process   = in_valid_ff && advance;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;
   assign csr_chan.ready = !reset;

   assign in_valid_in  = req_ready ? req_chan.valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   assign c  = in_ff.data_byte;
   // at line start the field counter restarts from zero
   assign fs = (mode_ff == csvt_pkg::MODE_LINE_START) ? '0 : fields_ff;

   always_comb begin
      result      = '0;
      mode_in     = mode_ff;
      fields_in   = fields_ff;
      len_in      = len_ff;
      crp_in      = crp_ff;
      halt_in     = halt_ff;
      line_end    = 1'b0;
      start_field = 1'b0;
      end_field   = 1'b0;
      emit        = 1'b0;
      rec_ok      = 1'b0;
      rec_fend    = 1'b0;
      rec_count   = '0;

      if (!halt_ff) begin
         if (in_ff.end_of_input) begin
            crp_in   = 1'b0;
            line_end = 1'b1;
         end else if (crp_ff && (c == csvt_pkg::CH_LF)) begin
            // drop the LF of a CRLF
            crp_in = 1'b0;
         end else if ((c == csvt_pkg::CH_CR) || (c == csvt_pkg::CH_LF)) begin
            crp_in   = (c == csvt_pkg::CH_CR);
            line_end = 1'b1;
         end else begin
            crp_in = 1'b0;
            if (len_ff >= max_line_ff) begin
               halt_in            = 1'b1;
               result.field_count = fields_ff;
               result.error_code  = csvt_pkg::ERR_TOO_LONG;
            end else begin
               len_in = len_ff + 1'b1;
               unique case (mode_ff)
                  csvt_pkg::MODE_LINE_START: begin
                     fields_in = '0;
                     if (c == csvt_pkg::CH_HASH) begin
                        mode_in = csvt_pkg::MODE_SKIP;
                     end else begin
                        start_field = 1'b1;
                     end
                  end
                  csvt_pkg::MODE_FIELD_START: begin
                     start_field = 1'b1;
                  end
                  csvt_pkg::MODE_UNQUOTED: begin
                     if (c == csvt_pkg::CH_COMMA) begin
                        end_field = 1'b1;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  csvt_pkg::MODE_QUOTED: begin
                     if (c == csvt_pkg::CH_QUOTE) begin
                        mode_in = csvt_pkg::MODE_QUOTE_SEEN;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  csvt_pkg::MODE_QUOTE_SEEN: begin
                     if (c == csvt_pkg::CH_QUOTE) begin
                        // doubled quote: literal quote, back inside the field
                        mode_in = csvt_pkg::MODE_QUOTED;
                        emit    = 1'b1;
                     end else if (c == csvt_pkg::CH_COMMA) begin
                        end_field = 1'b1;
                     end else begin
                        halt_in            = 1'b1;
                        result.field_count = fields_ff;
                        result.error_code  = csvt_pkg::ERR_JUNK;
                     end
                  end
                  csvt_pkg::MODE_SKIP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      if (start_field) begin
         if (fs >= csvt_pkg::COUNT_W'(csvt_pkg::MAX_FIELDS)) begin
            halt_in            = 1'b1;
            result.field_count = fs;
            result.error_code  = csvt_pkg::ERR_TOO_MANY;
         end else if (c == csvt_pkg::CH_QUOTE) begin
            mode_in = csvt_pkg::MODE_QUOTED;
         end else if (c == csvt_pkg::CH_COMMA) begin
            end_field = 1'b1;
         end else begin
            mode_in = csvt_pkg::MODE_UNQUOTED;
            emit    = 1'b1;
         end
      end

      if (emit) begin
         result.out_byte    = c;
         result.byte_valid  = 1'b1;
         result.field_index = fs[csvt_pkg::INDEX_W-1:0];
      end

      if (end_field) begin
         result.field_index = fs[csvt_pkg::INDEX_W-1:0];
         result.field_end   = 1'b1;
         fields_in          = fs + 1'b1;
         mode_in            = csvt_pkg::MODE_FIELD_START;
      end

      if (line_end) begin
         mode_in = csvt_pkg::MODE_LINE_START;
         len_in  = '0;
         unique case (mode_ff) inside
            csvt_pkg::MODE_QUOTED: begin
               halt_in            = 1'b1;
               result.field_count = fields_ff;
               result.error_code  = csvt_pkg::ERR_UNCLOSED;
            end
            csvt_pkg::MODE_FIELD_START: begin
               rec_ok    = 1'b1;
               rec_count = fields_ff;
            end
            csvt_pkg::MODE_UNQUOTED, csvt_pkg::MODE_QUOTE_SEEN: begin
               rec_ok    = 1'b1;
               rec_fend  = 1'b1;
               rec_count = fields_ff + 1'b1;
            end
            default: begin
               fields_in = '0;
            end
         endcase
         if (rec_ok) begin
            if ((expected_ff != '0) && (rec_count != expected_ff)) begin
               halt_in            = 1'b1;
               fields_in          = rec_count;
               result.field_count = rec_count;
               result.error_code  = csvt_pkg::ERR_MISMATCH;
            end else begin
               result.field_index = rec_fend ? fields_ff[csvt_pkg::INDEX_W-1:0] : '0;
               result.field_end   = rec_fend;
               result.record_end  = 1'b1;
               result.field_count = rec_count;
               fields_in          = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         expected_ff  <= csvt_pkg::RESET_EXPECTED;
         max_line_ff  <= csvt_pkg::RESET_MAX_LINE;
         mode_ff      <= csvt_pkg::MODE_LINE_START;
         fields_ff    <= '0;
         len_ff       <= '0;
         crp_ff       <= 1'b0;
         halt_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               csvt_pkg::CSR_EXPECTED_FIELDS: begin
                  expected_ff <= csr_chan.wdata[csvt_pkg::COUNT_W-1:0];
               end
               csvt_pkg::CSR_MAX_LINE_BYTES: begin
                  max_line_ff <= csr_chan.wdata[csvt_pkg::LINE_LEN_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (process) begin
            mode_ff   <= mode_in;
            fields_ff <= fields_in;
            len_ff    <= len_in;
            crp_ff    <= crp_in;
            halt_ff   <= halt_in;
         end
      end
   end

   // payload registers: load on handshake, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_chan.data;
      end
      if (process) begin
         rsp_ff <= result;
      end
   end

endmodule

`default_nettype wire

FILE: design/csvt_checker.sv
// Result-channel checks for the CSV record tokenizer, bound to the top level.
`default_nettype none

module csvt_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input csvt_pkg::rsp_type rsp_data
);

   logic seen_error_ff;
   logic seen_error_in;

   assign seen_error_in = seen_error_ff ||
                          (rsp_valid && rsp_ready && (rsp_data.error_code != csvt_pkg::ERR_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_error_ff <= 1'b0;
      end else begin
         seen_error_ff <= seen_error_in;
      end
   end

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_error_ff |-> rsp_data == '0)
      else $error("non-idle result word after an error");

   a_byte_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |->
         !rsp_data.field_end && !rsp_data.record_end &&
         (rsp_data.error_code == csvt_pkg::ERR_NONE))
      else $error("content byte mixed with an end or error");

   a_record_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_end && rsp_data.field_end |->
         rsp_data.field_count == ({1'b0, rsp_data.field_index} + 5'd1))
      else $error("record field count disagrees with last field index");

endmodule

bind csv_record_tokenizer_unit csvt_checker u_csvt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid_ff),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_ff)
);

`default_nettype wire
